// ===== src/chained_hash_table_defines.svh =====
// assertion macros used by the hash table checker
`ifndef CHAINED_HASH_TABLE_DEFINES_SVH
`define CHAINED_HASH_TABLE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CHT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CHT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/cht_pkg.sv =====
// shared types, constants and codes of the chained hash table
package cht_pkg;

    localparam int DEF_MAX_BUCKETS   = 256;
    localparam int DEF_BUCKET_DEPTH  = 8;
    localparam int DEF_FIRST_BUCKETS = 16;
    localparam int DEF_KEY_WIDTH     = 32;
    localparam int DEF_VALUE_WIDTH   = 32;

    localparam int KEY_BITS    = 32;
    localparam int VALUE_BITS  = 32;
    localparam int HASH_BITS   = 64;
    localparam int ENTRY_BITS  = 12;
    localparam int BUCKET_BITS = 9;

    // hash bits reduced per cycle by the remainder unit
    localparam int MOD_STEP   = 8;
    localparam int MOD_CYCLES = HASH_BITS / MOD_STEP;

    localparam logic [1:0] OP_PUT    = 2'd0;
    localparam logic [1:0] OP_GET    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    typedef struct packed {
        logic [1:0]            op;
        logic [KEY_BITS-1:0]   key;
        logic [HASH_BITS-1:0]  key_hash;
        logic [VALUE_BITS-1:0] value;
    } t_in;

    typedef struct packed {
        logic                   found;
        logic [VALUE_BITS-1:0]  result_value;
        logic                   overflow;
        logic [ENTRY_BITS-1:0]  entry_count;
        logic [BUCKET_BITS-1:0] bucket_count;
    } t_out;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_START, ST_MOD, ST_FILL_RD, ST_FILL_LD,
        ST_SCAN_RD, ST_SCAN_CMP, ST_SHIFT_RD, ST_SHIFT_WR, ST_CHECK,
        ST_GCLR, ST_GB_RD, ST_GB_LD, ST_GS_RD, ST_GS_LD, ST_GMOD,
        ST_GN_RD, ST_GN_LD, ST_DONE
    } t_state;

    typedef enum logic [1:0] {FS_ITEM, FS_OLD, FS_NEW} t_fsel;
    typedef enum logic [1:0] {SS_SCAN, SS_SHIFT, SS_MOVE} t_ssel;

    typedef struct packed {
        logic  item_ld;
        logic  mod_start;
        logic  mod_grow;
        logic  bucket_ld;
        t_fsel fill_sel;
        logic  fill_ld;
        t_ssel slot_sel;
        logic  idx_inc;
        logic  hit_ld;
        logic  wr_replace;
        logic  wr_append;
        logic  wr_shift;
        logic  rm_done;
        logic  ovf_set;
        logic  clr_start;
        logic  clr_wr;
        logic  clr_new;
        logic  gb_start;
        logic  gfill_ld;
        logic  gi_inc;
        logic  gb_inc;
        logic  move_ld;
        logic  nb_ld;
        logic  move_wr;
        logic  grow_done;
        logic  out_ld;
    } t_cmd;

    typedef struct packed {
        logic mod_done;
        logic op_put;
        logic op_find;
        logic op_rem;
        logic no_buckets;
        logic scan_end;
        logic hit;
        logic full;
        logic shift_end;
        logic grow_need;
        logic clr_last;
        logic gi_end;
        logic gb_last;
        logic gn_room;
        logic out_free;
    } t_status;

endpackage

// ===== src/chained_hash_table.sv =====
// chained hash table top level: sequencer plus datapath
//
//   channel   direction   payload          handshake
//   in        request     t_in             i_in_valid / o_in_stall
//   out       result      t_out            o_out_valid / i_out_stall
//
// one request at a time; a lookup finds its bucket on the iterative remainder unit,
// reads the bucket's fill count, then reads and compares its slots in turn. a remove
// shifts each later slot down by one; an appending put adds a growth check, and growth
// clears the new fill counts, then rehashes each entry of every old bucket into the
// spare bank. after reset the fill counts of MAX_BUCKETS buckets are cleared, stall
// high. a waiting result holds the next request only at its final step.
module chained_hash_table #(
    parameter int MAX_BUCKETS   = cht_pkg::DEF_MAX_BUCKETS,
    parameter int BUCKET_DEPTH  = cht_pkg::DEF_BUCKET_DEPTH,
    parameter int FIRST_BUCKETS = cht_pkg::DEF_FIRST_BUCKETS,
    parameter int KEY_WIDTH     = cht_pkg::DEF_KEY_WIDTH,
    parameter int VALUE_WIDTH   = cht_pkg::DEF_VALUE_WIDTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  cht_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output cht_pkg::t_out o_out_data
);
    import cht_pkg::*;

    t_cmd    cmd;
    t_status status;

    cht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    cht_datapath #(
        .MAX_BUCKETS   (MAX_BUCKETS),
        .BUCKET_DEPTH  (BUCKET_DEPTH),
        .FIRST_BUCKETS (FIRST_BUCKETS),
        .KEY_WIDTH     (KEY_WIDTH),
        .VALUE_WIDTH   (VALUE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== src/cht_mod.sv =====
// iterative remainder of the 64-bit hash by the bucket count
module cht_mod #(
    parameter int DIV_W = 9,
    parameter int REM_W = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [cht_pkg::HASH_BITS-1:0]  i_dividend,
    input  logic [DIV_W-1:0]               i_divisor,
    output logic                           o_done,
    output logic [REM_W-1:0]               o_rem
);
    import cht_pkg::*;

    localparam int CNT_W = (MOD_CYCLES > 1) ? $clog2(MOD_CYCLES) : 1;

    logic [HASH_BITS-1:0] r_quo, n_quo;
    logic [DIV_W-1:0]     r_rem, n_rem;
    logic [DIV_W-1:0]     r_div;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DIV_W:0]       trial;

    // restoring steps, one hash bit each
    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        trial = '0;
        for (int s = 0; s < MOD_STEP; s++) begin
            trial = {n_rem, n_quo[HASH_BITS-1]};
            if (trial >= {1'b0, r_div}) begin
                trial = trial - {1'b0, r_div};
            end
            n_rem = trial[DIV_W-1:0];
            n_quo = {n_quo[HASH_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(MOD_CYCLES - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[REM_W-1:0];

endmodule

// ===== src/cht_datapath.sv =====
// slot and fill memories, counters, item and result registers
module cht_datapath #(
    parameter int MAX_BUCKETS   = cht_pkg::DEF_MAX_BUCKETS,
    parameter int BUCKET_DEPTH  = cht_pkg::DEF_BUCKET_DEPTH,
    parameter int FIRST_BUCKETS = cht_pkg::DEF_FIRST_BUCKETS,
    parameter int KEY_WIDTH     = cht_pkg::DEF_KEY_WIDTH,
    parameter int VALUE_WIDTH   = cht_pkg::DEF_VALUE_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cht_pkg::t_cmd     i_cmd,
    output cht_pkg::t_status  o_status,
    input  cht_pkg::t_in      i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output cht_pkg::t_out     o_out_data
);
    import cht_pkg::*;

    localparam int KSW     = (KEY_WIDTH < KEY_BITS) ? KEY_WIDTH : KEY_BITS;
    localparam int VSW     = (VALUE_WIDTH < VALUE_BITS) ? VALUE_WIDTH : VALUE_BITS;
    localparam int BI_W    = $clog2(MAX_BUCKETS);
    localparam int NB_W    = $clog2(MAX_BUCKETS + 1);
    localparam int SI_W    = $clog2(BUCKET_DEPTH);
    localparam int FW      = $clog2(BUCKET_DEPTH + 1);
    localparam int EW      = $clog2(MAX_BUCKETS * BUCKET_DEPTH + 1);
    localparam int CW      = EW + 2;
    localparam int FA_W    = 1 + BI_W;
    localparam int SA_W    = 1 + BI_W + SI_W;
    localparam int FIRST_N = (FIRST_BUCKETS > MAX_BUCKETS) ? MAX_BUCKETS : FIRST_BUCKETS;

    typedef struct packed {
        logic [HASH_BITS-1:0] hash;
        logic [KSW-1:0]       key;
        logic [VSW-1:0]       value;
    } t_slot;

    // two banks: growth rehashes from the live bank into the spare one
    t_slot          slot_mem [2**SA_W];
    logic [FW-1:0]  fill_mem [2**FA_W];

    t_slot          r_slot_q;
    logic [FW-1:0]  r_fill_q;

    logic             r_bank;
    logic [NB_W-1:0]  r_buckets;
    logic [EW-1:0]    r_entries;
    logic [NB_W-1:0]  r_clr;
    logic             r_out_valid;
    t_out             r_out;

    logic [1:0]       r_op;
    logic [KSW-1:0]   r_key;
    logic [HASH_BITS-1:0] r_hash;
    logic [VSW-1:0]   r_value;
    logic [BI_W-1:0]  r_bucket;
    logic [FW-1:0]    r_fill;
    logic [FW-1:0]    r_idx;
    logic             r_found;
    logic             r_ovf;
    logic [VSW-1:0]   r_old;
    logic [BI_W-1:0]  r_gb;
    logic [FW-1:0]    r_gfill;
    logic [FW-1:0]    r_gi;
    t_slot            r_mv;
    logic [BI_W-1:0]  r_nb;

    logic [NB_W:0]    new_n;
    logic [NB_W:0]    clr_lim;
    logic [CW-1:0]    b3;
    logic             mod_done;
    logic [BI_W-1:0]  mod_rem;
    logic [FA_W-1:0]  fill_ra, fill_wa;
    logic [FW-1:0]    fill_wd;
    logic             fill_we;
    logic [SA_W-1:0]  slot_ra, slot_wa;
    t_slot            slot_wd;
    logic             slot_we;
    logic             out_free;
    t_slot            item_slot;

    assign new_n     = {r_buckets, 1'b0};
    assign clr_lim   = i_cmd.clr_new ? new_n : (NB_W + 1)'(MAX_BUCKETS);
    assign b3        = CW'(r_buckets) + (CW'(r_buckets) << 1);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign item_slot = '{hash: r_hash, key: r_key, value: r_value};

    cht_mod #(
        .DIV_W (NB_W),
        .REM_W (BI_W)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.mod_start),
        .i_dividend (i_cmd.mod_grow ? r_slot_q.hash : r_hash),
        .i_divisor  (i_cmd.mod_grow ? new_n[NB_W-1:0] : r_buckets),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // read addresses
    always_comb begin
        case (i_cmd.fill_sel)
            FS_OLD:  fill_ra = {r_bank, r_gb};
            FS_NEW:  fill_ra = {~r_bank, r_nb};
            default: fill_ra = {r_bank, r_bucket};
        endcase
        case (i_cmd.slot_sel)
            SS_SHIFT: slot_ra = {r_bank, r_bucket, SI_W'(r_idx + 1'b1)};
            SS_MOVE:  slot_ra = {r_bank, r_gb, r_gi[SI_W-1:0]};
            default:  slot_ra = {r_bank, r_bucket, r_idx[SI_W-1:0]};
        endcase
    end

    // write ports
    always_comb begin
        slot_we = 1'b0;
        slot_wa = {r_bank, r_bucket, r_idx[SI_W-1:0]};
        slot_wd = item_slot;
        if (i_cmd.wr_replace) begin
            slot_we = 1'b1;
        end else if (i_cmd.wr_append) begin
            slot_we = 1'b1;
            slot_wa = {r_bank, r_bucket, r_fill[SI_W-1:0]};
        end else if (i_cmd.wr_shift) begin
            slot_we = 1'b1;
            slot_wd = r_slot_q;
        end else if (i_cmd.move_wr) begin
            slot_we = 1'b1;
            slot_wa = {~r_bank, r_nb, r_fill_q[SI_W-1:0]};
            slot_wd = r_mv;
        end

        fill_we = 1'b0;
        fill_wa = {r_bank, r_bucket};
        fill_wd = r_fill + 1'b1;
        if (i_cmd.wr_append) begin
            fill_we = 1'b1;
        end else if (i_cmd.rm_done) begin
            fill_we = 1'b1;
            fill_wd = r_fill - 1'b1;
        end else if (i_cmd.clr_wr) begin
            fill_we = 1'b1;
            fill_wa = {i_cmd.clr_new ? ~r_bank : r_bank, r_clr[BI_W-1:0]};
            fill_wd = '0;
        end else if (i_cmd.move_wr) begin
            fill_we = 1'b1;
            fill_wa = {~r_bank, r_nb};
            fill_wd = r_fill_q + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            slot_mem[slot_wa] <= slot_wd;
        end
        r_slot_q <= slot_mem[slot_ra];
    end

    always_ff @(posedge i_clk) begin
        if (fill_we) begin
            fill_mem[fill_wa] <= fill_wd;
        end
        r_fill_q <= fill_mem[fill_ra];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank      <= 1'b0;
            r_buckets   <= '0;
            r_entries   <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.item_ld && i_in_data.op == OP_PUT && r_buckets == '0) begin
                r_buckets <= NB_W'(FIRST_N);
            end
            if (i_cmd.grow_done) begin
                r_bank    <= ~r_bank;
                r_buckets <= new_n[NB_W-1:0];
            end
            if (i_cmd.wr_append) begin
                r_entries <= r_entries + 1'b1;
            end else if (i_cmd.rm_done) begin
                r_entries <= r_entries - 1'b1;
            end
            if (i_cmd.clr_start) begin
                r_clr <= '0;
            end else if (i_cmd.clr_wr) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.out_ld) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request and walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.item_ld) begin
            r_op    <= i_in_data.op;
            r_key   <= KSW'(i_in_data.key);
            r_hash  <= i_in_data.key_hash;
            r_value <= VSW'(i_in_data.value);
            r_found <= 1'b0;
            r_ovf   <= 1'b0;
            r_old   <= '0;
        end
        if (i_cmd.bucket_ld) begin
            r_bucket <= mod_rem;
        end
        if (i_cmd.fill_ld) begin
            r_fill <= r_fill_q;
            r_idx  <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.hit_ld) begin
            r_found <= 1'b1;
            r_old   <= r_slot_q.value;
        end
        if (i_cmd.ovf_set) begin
            r_ovf <= 1'b1;
        end
        if (i_cmd.gb_start) begin
            r_gb <= '0;
        end else if (i_cmd.gb_inc) begin
            r_gb <= r_gb + 1'b1;
        end
        if (i_cmd.gfill_ld) begin
            r_gfill <= r_fill_q;
            r_gi    <= '0;
        end else if (i_cmd.gi_inc) begin
            r_gi <= r_gi + 1'b1;
        end
        if (i_cmd.move_ld) begin
            r_mv <= r_slot_q;
        end
        if (i_cmd.nb_ld) begin
            r_nb <= mod_rem;
        end
        if (i_cmd.out_ld) begin
            r_out.found        <= r_found;
            r_out.result_value <= VALUE_BITS'(r_old);
            r_out.overflow     <= r_ovf;
            r_out.entry_count  <= ENTRY_BITS'(r_entries);
            r_out.bucket_count <= BUCKET_BITS'(r_buckets);
        end
    end

    always_comb begin
        o_status.mod_done   = mod_done;
        o_status.op_put     = (r_op == OP_PUT);
        o_status.op_find    = (r_op == OP_GET) || (r_op == OP_REMOVE);
        o_status.op_rem     = (r_op == OP_REMOVE);
        o_status.no_buckets = (r_buckets == '0);
        o_status.scan_end   = (r_idx == r_fill);
        o_status.hit        = (r_slot_q.hash == r_hash) && (r_slot_q.key == r_key);
        o_status.full       = (r_fill >= FW'(BUCKET_DEPTH));
        o_status.shift_end  = ((FW + 1)'(r_idx) + 1'b1) >= (FW + 1)'(r_fill);
        o_status.grow_need  = ({r_entries, 2'b00} >= b3)
                              && (new_n <= (NB_W + 1)'(MAX_BUCKETS));
        o_status.clr_last   = ({1'b0, r_clr} == clr_lim - 1'b1);
        o_status.gi_end     = (r_gi == r_gfill);
        o_status.gb_last    = (NB_W'(r_gb) == r_buckets - 1'b1);
        o_status.gn_room    = (r_fill_q < FW'(BUCKET_DEPTH));
        o_status.out_free   = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== src/cht_ctrl.sv =====
// sequencer for lookups, updates, removal shifts and rehashing
module cht_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  cht_pkg::t_status  i_status,
    output cht_pkg::t_cmd     o_cmd
);
    import cht_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:    if (i_status.clr_last) n_state = ST_IDLE;
            ST_IDLE:     if (i_in_valid) n_state = ST_START;
            ST_START: begin
                if (i_status.op_put || (i_status.op_find && !i_status.no_buckets)) begin
                    n_state = ST_MOD;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_MOD:      if (i_status.mod_done) n_state = ST_FILL_RD;
            ST_FILL_RD:  n_state = ST_FILL_LD;
            ST_FILL_LD:  n_state = ST_SCAN_RD;
            ST_SCAN_RD: begin
                if (!i_status.scan_end) begin
                    n_state = ST_SCAN_CMP;
                end else if (i_status.op_put && !i_status.full) begin
                    n_state = ST_CHECK;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_SCAN_CMP: begin
                if (!i_status.hit) begin
                    n_state = ST_SCAN_RD;
                end else if (i_status.op_rem) begin
                    n_state = ST_SHIFT_RD;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_SHIFT_RD: n_state = i_status.shift_end ? ST_DONE : ST_SHIFT_WR;
            ST_SHIFT_WR: n_state = ST_SHIFT_RD;
            ST_CHECK:    n_state = i_status.grow_need ? ST_GCLR : ST_DONE;
            ST_GCLR:     if (i_status.clr_last) n_state = ST_GB_RD;
            ST_GB_RD:    n_state = ST_GB_LD;
            ST_GB_LD:    n_state = ST_GS_RD;
            ST_GS_RD: begin
                if (!i_status.gi_end) begin
                    n_state = ST_GS_LD;
                end else if (i_status.gb_last) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_GB_RD;
                end
            end
            ST_GS_LD:    n_state = ST_GMOD;
            ST_GMOD:     if (i_status.mod_done) n_state = ST_GN_RD;
            ST_GN_RD:    n_state = ST_GN_LD;
            ST_GN_LD:    n_state = ST_GS_RD;
            ST_DONE:     if (i_status.out_free) n_state = ST_IDLE;
            default:     n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.fill_sel = FS_ITEM;
        o_cmd.slot_sel = SS_SCAN;
        case (r_state)
            ST_CLEAR:   o_cmd.clr_wr = 1'b1;
            ST_IDLE:    o_cmd.item_ld = i_in_valid;
            ST_START: begin
                o_cmd.mod_start = i_status.op_put
                                  || (i_status.op_find && !i_status.no_buckets);
            end
            ST_MOD:     o_cmd.bucket_ld = i_status.mod_done;
            ST_FILL_RD: o_cmd.fill_sel = FS_ITEM;
            ST_FILL_LD: o_cmd.fill_ld = 1'b1;
            ST_SCAN_RD: begin
                o_cmd.slot_sel = SS_SCAN;
                if (i_status.scan_end && i_status.op_put) begin
                    o_cmd.ovf_set   = i_status.full;
                    o_cmd.wr_append = !i_status.full;
                end
            end
            ST_SCAN_CMP: begin
                o_cmd.hit_ld     = i_status.hit;
                o_cmd.wr_replace = i_status.hit && i_status.op_put;
                o_cmd.idx_inc    = !i_status.hit;
            end
            ST_SHIFT_RD: begin
                o_cmd.slot_sel = SS_SHIFT;
                o_cmd.rm_done  = i_status.shift_end;
            end
            ST_SHIFT_WR: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.idx_inc  = 1'b1;
            end
            ST_CHECK:   o_cmd.clr_start = i_status.grow_need;
            ST_GCLR: begin
                o_cmd.clr_wr   = 1'b1;
                o_cmd.clr_new  = 1'b1;
                o_cmd.gb_start = i_status.clr_last;
            end
            ST_GB_RD:   o_cmd.fill_sel = FS_OLD;
            ST_GB_LD:   o_cmd.gfill_ld = 1'b1;
            ST_GS_RD: begin
                o_cmd.slot_sel  = SS_MOVE;
                o_cmd.grow_done = i_status.gi_end && i_status.gb_last;
                o_cmd.gb_inc    = i_status.gi_end && !i_status.gb_last;
            end
            ST_GS_LD: begin
                o_cmd.move_ld   = 1'b1;
                o_cmd.mod_start = 1'b1;
                o_cmd.mod_grow  = 1'b1;
            end
            ST_GMOD:    o_cmd.nb_ld = i_status.mod_done;
            ST_GN_RD:   o_cmd.fill_sel = FS_NEW;
            ST_GN_LD: begin
                o_cmd.move_wr = i_status.gn_room;
                o_cmd.gi_inc  = 1'b1;
            end
            ST_DONE:    o_cmd.out_ld = i_status.out_free;
            default:    o_cmd.out_ld = 1'b0;
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

// ===== src/cht_checker.sv =====
// port-level checks of the hash table, bound to the top level
`include "chained_hash_table_defines.svh"

module cht_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input cht_pkg::t_out o_out_data
);

    `CHT_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "result changed while stalled")

    `CHT_ASSERT_NEXT(a_one_request, i_in_valid && !o_in_stall, o_in_stall, "second request taken while one is in flight")

    `CHT_ASSERT_NOW(a_miss_zero, o_out_valid && !o_out_data.found, o_out_data.result_value == '0, "value returned for a missing key")

    `CHT_ASSERT_NOW(a_ovf_miss, o_out_valid && o_out_data.overflow, !o_out_data.found, "overflow flagged on a present key")

    `CHT_ASSERT_NOW(a_buckets_live, o_out_valid && o_out_data.entry_count != '0, o_out_data.bucket_count != '0, "entries stored without buckets")

endmodule

bind chained_hash_table cht_checker u_cht_checker (.*);
